>>> hdl/zph_pkg.sv
// ----------------------------------------------------------------------------
// zph_pkg
// Shared constants, types and codes of the Zobrist position hasher.
// ----------------------------------------------------------------------------
package zph_pkg;

  // Board geometry and key store size.
  localparam int BOARD_DIM = 15;
  localparam int CELLS     = BOARD_DIM * BOARD_DIM;
  localparam int KEY_COUNT = 2 * CELLS;
  localparam int KEY_AW    = $clog2(KEY_COUNT);
  localparam int CNT_W     = $clog2(KEY_COUNT + 1);

  // Generator constants.
  localparam logic [63:0] GOLDEN_STEP = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MIX_A       = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MIX_B       = 64'h94D0_49BB_1331_11EB;

  // Operation codes.
  localparam logic [1:0] OP_PIECE = 2'd0;
  localparam logic [1:0] OP_SIDE  = 2'd1;
  localparam logic [1:0] OP_CELL  = 2'd2;

  // Cell colors.
  localparam logic [1:0] COLOR_BLACK = 2'd1;
  localparam logic [1:0] COLOR_WHITE = 2'd2;

  typedef logic [KEY_AW-1:0] key_addr_t;
  typedef logic [CNT_W-1:0]  key_cnt_t;

  // Write port of the key store, driven by the generator.
  typedef struct packed {
    logic        wr_en;
    key_addr_t   wr_addr;
    logic [63:0] wr_data;
  } zph_key_wr_t;

  // Generator status seen by the datapath.
  typedef struct packed {
    logic        done;
    logic [63:0] side_key;
  } zph_gen_status_t;

endpackage

>>> hdl/zph_key_ram.sv
// ----------------------------------------------------------------------------
// zph_key_ram
// Piece key store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module zph_key_ram (
  input  logic                 clk,
  input  zph_pkg::zph_key_wr_t wr,
  input  logic                 rd_en,
  input  zph_pkg::key_addr_t   rd_addr,
  output logic [63:0]          rd_data
);

  logic [63:0] mem [zph_pkg::KEY_COUNT];

  // Write from the generator during the fill.
  always_ff @(posedge clk) begin
    if (wr.wr_en) begin
      mem[wr.wr_addr] <= wr.wr_data;
    end
  end

  // Registered read; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/zph_keygen.sv
// ----------------------------------------------------------------------------
// zph_keygen
// Splitmix64 key generator that fills the key store after reset.
// Each 64-bit product is built from three 32x32 partial products on one
// shared multiplier.
// ----------------------------------------------------------------------------
module zph_keygen (
  input  logic                     clk,
  input  logic                     rst,
  output zph_pkg::zph_key_wr_t     wr,
  output zph_pkg::zph_gen_status_t status
);

  localparam logic [1:0] ST_ADV  = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_MIX  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]        state;
  logic [1:0]        step;
  logic              mul_sel;
  zph_pkg::key_cnt_t cnt;
  logic [63:0]       gen_s;
  logic [63:0]       z;
  logic [63:0]       acc;
  logic [63:0]       side_key;
  logic              done;

  logic [63:0] s_sum;
  logic [63:0] mix_const;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [63:0] key_val;
  logic        key_ready;

  // Operand selection for the shared partial-product multiplier.
  always_comb begin
    s_sum     = gen_s + zph_pkg::GOLDEN_STEP;
    mix_const = mul_sel ? zph_pkg::MIX_B : zph_pkg::MIX_A;
    mul_a     = (step == 2'd2) ? z[63:32] : z[31:0];
    mul_b     = (step == 2'd1) ? mix_const[63:32] : mix_const[31:0];
    prod      = 64'(mul_a) * 64'(mul_b);
    key_val   = acc ^ (acc >> 31);
    key_ready = (state == ST_MIX) && mul_sel;
  end

  // Sequencer: advance state, two multiplies with mixing, then store.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_ADV;
      step    <= 2'd0;
      mul_sel <= 1'b0;
      cnt     <= '0;
      gen_s   <= zph_pkg::GOLDEN_STEP;
      done    <= 1'b0;
    end else begin
      unique case (state)
        ST_ADV: begin
          gen_s   <= s_sum;
          z       <= s_sum ^ (s_sum >> 30);
          mul_sel <= 1'b0;
          step    <= 2'd0;
          state   <= ST_MUL;
        end
        ST_MUL: begin
          if (step == 2'd0) begin
            acc <= prod;
          end else begin
            acc[63:32] <= acc[63:32] + prod[31:0];
          end
          if (step == 2'd2) begin
            step  <= 2'd0;
            state <= ST_MIX;
          end else begin
            step <= step + 2'd1;
          end
        end
        ST_MIX: begin
          if (!mul_sel) begin
            z       <= acc ^ (acc >> 27);
            mul_sel <= 1'b1;
            state   <= ST_MUL;
          end else if (cnt == zph_pkg::key_cnt_t'(zph_pkg::KEY_COUNT)) begin
            side_key <= key_val;
            done     <= 1'b1;
            state    <= ST_DONE;
          end else begin
            cnt   <= cnt + 1'b1;
            state <= ST_ADV;
          end
        end
        default: begin
          state <= ST_DONE;
        end
      endcase
    end
  end

  // Piece keys go to the store; the last value becomes the side key.
  always_comb begin
    wr.wr_en   = key_ready && (cnt != zph_pkg::key_cnt_t'(zph_pkg::KEY_COUNT));
    wr.wr_addr = cnt[zph_pkg::KEY_AW-1:0];
    wr.wr_data = key_val;
    status.done     = done;
    status.side_key = side_key;
  end

endmodule

>>> hdl/zobrist_position_hasher.sv
// ----------------------------------------------------------------------------
// zobrist_position_hasher
// Zobrist hashing of board positions with splitmix64 keys.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries one operation per transaction:
// xor a piece key into hash_in, xor the side key into hash_in, or stream
// one board cell into the running hash. Output channel (out_valid /
// out_stall) carries hash_out for piece and side operations and for the
// streamed cell marked last_cell.
// After reset the key store is filled: the key generator makes 451 keys
// on its shared 32x32 multiplier, 450 piece keys and then the side key.
// in_stall stays high until the fill ends.
// Then one transaction is taken every cycle unless in_stall rises as below.
// A result passes the registered key store read, then the xor into the
// output register.
// When the receiver stalls, one result waits in the output register while
// the next item waits in the read stage; in_stall rises only when both
// are full.
// ----------------------------------------------------------------------------
module zobrist_position_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [63:0] hash_in,
  input  logic [3:0]  row,
  input  logic [3:0]  col,
  input  logic [1:0]  cell_color,
  input  logic        white_to_move,
  input  logic        last_cell,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] hash_out
);

  zph_pkg::zph_key_wr_t     gen_wr;
  zph_pkg::zph_gen_status_t gen_status;

  logic               in_fire;
  logic               hit;
  zph_pkg::key_addr_t rd_addr;
  logic [63:0]        rd_data;

  logic        s1_valid;
  logic [1:0]  s1_op;
  logic        s1_hit;
  logic [63:0] s1_hash_in;
  logic        s1_white;
  logic        s1_last;

  logic        s1_produce;
  logic        s1_advance;
  logic        s1_fire;
  logic [63:0] key;
  logic [63:0] run_xor;
  logic [63:0] result;
  logic [63:0] running_hash;

  // Key generator and key store.
  zph_keygen u_keygen (
    .clk    (clk),
    .rst    (rst),
    .wr     (gen_wr),
    .status (gen_status)
  );

  zph_key_ram u_key_ram (
    .clk     (clk),
    .wr      (gen_wr),
    .rd_en   (in_fire),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Key selection and store address for the incoming item. Items that select
  // no key read entry zero so the address always stays inside the store.
  always_comb begin
    hit = ((cell_color == zph_pkg::COLOR_BLACK) || (cell_color == zph_pkg::COLOR_WHITE)) &&
          (row < 4'(zph_pkg::BOARD_DIM)) && (col < 4'(zph_pkg::BOARD_DIM));
    rd_addr = ((cell_color == zph_pkg::COLOR_WHITE) ?
                 zph_pkg::key_addr_t'(zph_pkg::CELLS) : zph_pkg::key_addr_t'(0)) +
              zph_pkg::key_addr_t'(row) * zph_pkg::key_addr_t'(zph_pkg::BOARD_DIM) +
              zph_pkg::key_addr_t'(col);
    if (!hit) begin
      rd_addr = zph_pkg::key_addr_t'(0);
    end
  end

  // Handshake of the read stage.
  always_comb begin
    s1_produce = (s1_op == zph_pkg::OP_PIECE) || (s1_op == zph_pkg::OP_SIDE) ||
                 ((s1_op == zph_pkg::OP_CELL) && s1_last);
    s1_advance = !s1_produce || !out_valid || !out_stall;
    s1_fire    = s1_valid && s1_advance;
    in_stall   = !gen_status.done || (s1_valid && !s1_advance);
    in_fire    = in_valid && !in_stall;
  end

  // Read stage registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op      <= operation;
      s1_hit     <= hit;
      s1_hash_in <= hash_in;
      s1_white   <= white_to_move;
      s1_last    <= last_cell;
    end
  end

  // Result of the item in the read stage.
  always_comb begin
    key     = s1_hit ? rd_data : 64'd0;
    run_xor = running_hash ^ key;
    unique case (s1_op)
      zph_pkg::OP_PIECE: result = s1_hash_in ^ key;
      zph_pkg::OP_SIDE:  result = s1_hash_in ^ gen_status.side_key;
      default:           result = s1_white ? (run_xor ^ gen_status.side_key) : run_xor;
    endcase
  end

  // Running hash of a streamed board scan.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= 64'd0;
    end else if (s1_fire && (s1_op == zph_pkg::OP_CELL)) begin
      running_hash <= s1_last ? 64'd0 : run_xor;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_produce) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_produce) begin
      hash_out <= result;
    end
  end

  // Checks.
  a_no_accept_in_fill: assert property (@(posedge clk) disable iff (rst)
    in_fire |-> gen_status.done)
    else $error("input transaction accepted during key fill");

  a_no_write_after_fill: assert property (@(posedge clk) disable iff (rst)
    gen_wr.wr_en |-> !gen_status.done)
    else $error("key store written after fill");

  a_out_from_stage: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid))
    else $error("result appeared without an item in the read stage");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_advance) |=> (s1_valid && $stable(s1_hash_in) && $stable(rd_data)))
    else $error("stalled read stage lost its item");

endmodule

>>> test/zph_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zph_checker
// Watches both channels of the Zobrist hasher and checks every result.
// It builds its own copy of the splitmix64 key store and predicts the
// hash of each accepted input transaction. Results are compared in order.
// ----------------------------------------------------------------------------
module zph_checker
  import zph_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [63:0] hash_in,
  input  logic [3:0]  row,
  input  logic [3:0]  col,
  input  logic [1:0]  cell_color,
  input  logic        white_to_move,
  input  logic        last_cell,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [63:0] hash_out,
  output int          fail_count,
  output int          pending_count,
  output int          checked_count
);

  logic [63:0] key_table [KEY_COUNT];
  logic [63:0] turn_key;
  logic [63:0] scan_hash;
  logic [63:0] expected_hashes [$];
  int          errors;
  int          checks;

  // Output stage of splitmix64 for one generator state.
  function automatic logic [63:0] mix_state(input logic [63:0] gen_state);
    logic [63:0] z;
    z = gen_state;
    z = (z ^ (z >> 30)) * MIX_A;
    z = (z ^ (z >> 27)) * MIX_B;
    return z ^ (z >> 31);
  endfunction

  // Looks up the piece key for a colored cell on the board.
  function automatic logic key_lookup(input logic [3:0] r, input logic [3:0] c,
                                      input logic [1:0] clr, output logic [63:0] key);
    int idx;
    key = '0;
    if (clr != COLOR_BLACK && clr != COLOR_WHITE) return 1'b0;
    if (r >= BOARD_DIM || c >= BOARD_DIM) return 1'b0;
    idx = ((clr == COLOR_WHITE) ? CELLS : 0) + int'(r) * BOARD_DIM + int'(c);
    key = key_table[idx];
    return 1'b1;
  endfunction

  // Predicts the hash for one input transaction and advances the scan state.
  function automatic void predict_hash(output logic has_result, output logic [63:0] hash);
    logic [63:0] key;
    logic        hit;
    has_result = 1'b0;
    hash       = '0;
    hit        = key_lookup(row, col, cell_color, key);
    case (operation)
      OP_PIECE: begin
        has_result = 1'b1;
        hash       = hit ? (hash_in ^ key) : hash_in;
      end
      OP_SIDE: begin
        has_result = 1'b1;
        hash       = hash_in ^ turn_key;
      end
      OP_CELL: begin
        if (hit) scan_hash = scan_hash ^ key;
        if (last_cell) begin
          has_result = 1'b1;
          hash       = white_to_move ? (scan_hash ^ turn_key) : scan_hash;
          scan_hash  = '0;
        end
      end
      default: ;
    endcase
  endfunction

  // Key store as it stands after the fill: black keys, white keys, side key.
  initial begin
    logic [63:0] gen_state;
    gen_state = GOLDEN_STEP;
    for (int i = 0; i < KEY_COUNT; i++) begin
      gen_state    = gen_state + GOLDEN_STEP;
      key_table[i] = mix_state(gen_state);
    end
    gen_state = gen_state + GOLDEN_STEP;
    turn_key  = mix_state(gen_state);
    scan_hash = '0;
    errors    = 0;
    checks    = 0;
  end

  // Compare accepted results first, then queue the prediction for new input.
  always @(posedge clk) begin : monitor
    logic        has_result;
    logic [63:0] predicted;
    logic [63:0] oldest;
    if (rst) begin
      expected_hashes.delete();
      scan_hash = '0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_hashes.size() == 0) begin
          $error("hash_out: no result expected, actual %h", hash_out);
          errors++;
        end else begin
          oldest = expected_hashes.pop_front();
          checks++;
          if (hash_out !== oldest) begin
            $error("hash_out mismatch: expected %h, actual %h", oldest, hash_out);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        predict_hash(has_result, predicted);
        if (has_result) expected_hashes.push_back(predicted);
      end
    end
    fail_count    <= errors;
    pending_count <= expected_hashes.size();
    checked_count <= checks;
  end

endmodule

>>> test/tb_zobrist_position_hasher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_zobrist_position_hasher
// Stimulus and verdict for the Zobrist position hasher.
// After the key fill, a directed set covers board corners, empty and
// invalid colors, off-board positions and short scans. Random piece, side
// and scan transactions follow under four sender idle / receiver stall
// phases. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_zobrist_position_hasher;
  import zph_pkg::*;

  // Codes that the package does not name.
  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam logic [1:0] COLOR_EMPTY = 2'd0;
  localparam logic [1:0] COLOR_BAD   = 2'd3;
  localparam logic [3:0] EDGE_POS    = 4'(BOARD_DIM - 1);
  localparam logic [3:0] OFF_POS     = 4'd15;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        in_valid      = 1'b0;
  logic        in_stall;
  logic [1:0]  operation     = '0;
  logic [63:0] hash_in       = '0;
  logic [3:0]  row           = '0;
  logic [3:0]  col           = '0;
  logic [1:0]  cell_color    = '0;
  logic        white_to_move = 1'b0;
  logic        last_cell     = 1'b0;
  logic        out_valid;
  logic        out_stall     = 1'b0;
  logic [63:0] hash_out;

  int fail_count;
  int pending_count;
  int checked_count;
  int idle_pct  = 0;
  int stall_pct = 0;
  int items_sent = 0;

  zobrist_position_hasher u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .operation     (operation),
    .hash_in       (hash_in),
    .row           (row),
    .col           (col),
    .cell_color    (cell_color),
    .white_to_move (white_to_move),
    .last_cell     (last_cell),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .hash_out      (hash_out)
  );

  zph_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .operation     (operation),
    .hash_in       (hash_in),
    .row           (row),
    .col           (col),
    .cell_color    (cell_color),
    .white_to_move (white_to_move),
    .last_cell     (last_cell),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .hash_out      (hash_out),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .checked_count (checked_count)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Receiver back-pressure at the rate of the current phase.
  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // Hard limit on the run, well beyond the key fill and the slowest phase.
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic logic [63:0] random_hash();
    return {$urandom(), $urandom()};
  endfunction

  // Mostly on-board positions, sometimes past the edge.
  function automatic logic [3:0] random_pos();
    return ($urandom_range(7) == 0) ? 4'($urandom_range(15, BOARD_DIM))
                                    : 4'($urandom_range(BOARD_DIM - 1));
  endfunction

  // Mostly stones, with empty and invalid colors mixed in.
  function automatic logic [1:0] random_color();
    int pick;
    pick = $urandom_range(9);
    if (pick < 4) return COLOR_BLACK;
    if (pick < 8) return COLOR_WHITE;
    return (pick == 8) ? COLOR_EMPTY : COLOR_BAD;
  endfunction

  // Presents one transaction, possibly after an idle gap, and waits for it
  // to be taken. Valid stays high afterwards so items can go back to back.
  task automatic send_item(input logic [1:0] op, input logic [63:0] h,
                           input logic [3:0] r, input logic [3:0] c,
                           input logic [1:0] clr, input logic w, input logic l);
    int gap;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      gap = $urandom_range(3, 1);
      repeat (gap) @(posedge clk);
    end
    operation     <= op;
    hash_in       <= h;
    row           <= r;
    col           <= c;
    cell_color    <= clr;
    white_to_move <= w;
    last_cell     <= l;
    in_valid      <= 1'b1;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Holds the sender off until every outstanding result has arrived.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  // One scan of random cells, the final one marked last.
  task automatic send_scan(input int len);
    for (int i = 0; i < len; i++)
      send_item(OP_CELL, random_hash(), random_pos(), random_pos(), random_color(),
                1'($urandom_range(1)), (i == len - 1));
  endtask

  // Random mix of piece, side, scan and unused transactions.
  task automatic random_phase(input int item_budget);
    int sent;
    int pick;
    int len;
    sent = 0;
    while (sent < item_budget) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        send_item(OP_PIECE, random_hash(), random_pos(), random_pos(), random_color(),
                  1'($urandom_range(1)), 1'($urandom_range(1)));
        sent++;
      end else if (pick < 45) begin
        send_item(OP_SIDE, random_hash(), 4'($urandom_range(15)), 4'($urandom_range(15)),
                  2'($urandom_range(3)), 1'($urandom_range(1)), 1'($urandom_range(1)));
        sent++;
      end else if (pick < 95) begin
        len = $urandom_range(12, 1);
        send_scan(len);
        sent += len;
      end else begin
        send_item(OP_UNUSED, random_hash(), random_pos(), random_pos(), random_color(),
                  1'($urandom_range(1)), 1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    // Reset; the block then fills its key store with in_stall high.
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Piece keys at the four corners, with both extreme hash values.
    send_item(OP_PIECE, '1, 4'd0, 4'd0, COLOR_BLACK, 1'b0, 1'b0);
    send_item(OP_PIECE, '0, EDGE_POS, EDGE_POS, COLOR_WHITE, 1'b1, 1'b1);
    send_item(OP_PIECE, '0, EDGE_POS, 4'd0, COLOR_BLACK, 1'b0, 1'b0);
    send_item(OP_PIECE, '1, 4'd0, EDGE_POS, COLOR_WHITE, 1'b0, 1'b0);
    // No key selected: empty or invalid color, row or column off the board.
    send_item(OP_PIECE, 64'hDEAD_BEEF_0123_4567, 4'd3, 4'd4, COLOR_EMPTY, 1'b0, 1'b0);
    send_item(OP_PIECE, 64'h0123_4567_89AB_CDEF, 4'd3, 4'd4, COLOR_BAD, 1'b0, 1'b0);
    send_item(OP_PIECE, 64'hFEDC_BA98_7654_3210, OFF_POS, 4'd2, COLOR_BLACK, 1'b0, 1'b0);
    send_item(OP_PIECE, 64'h5555_AAAA_5555_AAAA, 4'd2, OFF_POS, COLOR_WHITE, 1'b0, 1'b0);
    // Side key on both extremes.
    send_item(OP_SIDE, '0, 4'd0, 4'd0, COLOR_EMPTY, 1'b0, 1'b0);
    send_item(OP_SIDE, '1, OFF_POS, OFF_POS, COLOR_BAD, 1'b1, 1'b1);
    // Unused operation gives nothing and must not disturb a scan.
    send_item(OP_UNUSED, '1, 4'd1, 4'd1, COLOR_BLACK, 1'b1, 1'b1);
    // Scan with empty, invalid and off-board cells; white_to_move ignored
    // until the last cell, which applies the side key.
    send_item(OP_CELL, '0, 4'd0, 4'd0, COLOR_BLACK, 1'b1, 1'b0);
    send_item(OP_CELL, '0, 4'd0, 4'd1, COLOR_EMPTY, 1'b0, 1'b0);
    send_item(OP_CELL, '0, 4'd7, 4'd7, COLOR_WHITE, 1'b1, 1'b0);
    send_item(OP_UNUSED, '0, 4'd7, 4'd8, COLOR_WHITE, 1'b0, 1'b1);
    send_item(OP_CELL, '0, OFF_POS, 4'd7, COLOR_WHITE, 1'b0, 1'b0);
    send_item(OP_CELL, '0, 4'd9, 4'd9, COLOR_BAD, 1'b0, 1'b0);
    send_item(OP_CELL, '0, EDGE_POS, EDGE_POS, COLOR_WHITE, 1'b1, 1'b1);
    // Scan ending with black to move; then single empty cells both ways.
    send_item(OP_CELL, '1, 4'd5, 4'd6, COLOR_BLACK, 1'b0, 1'b0);
    send_item(OP_CELL, '1, 4'd6, 4'd5, COLOR_WHITE, 1'b0, 1'b1);
    send_item(OP_CELL, '0, 4'd0, 4'd0, COLOR_EMPTY, 1'b0, 1'b1);
    send_item(OP_CELL, '0, 4'd0, 4'd0, COLOR_EMPTY, 1'b1, 1'b1);
    drain();

    // One full row-major board scan at full rate.
    for (int i = 0; i < CELLS; i++)
      send_item(OP_CELL, random_hash(), 4'(i / BOARD_DIM), 4'(i % BOARD_DIM),
                random_color(), 1'($urandom_range(1)), (i == CELLS - 1));

    // Random phases: no idling, sender idle, receiver stalling, both light.
    random_phase(200);
    drain();
    idle_pct = 50;
    random_phase(200);
    drain();
    idle_pct  = 0;
    stall_pct = 50;
    random_phase(200);
    drain();
    idle_pct  = 8;
    stall_pct = 8;
    random_phase(200);

    // Let the pipeline empty out.
    drain();
    repeat (10) @(posedge clk);

    $display("Run covered %0d input transactions and %0d checked results,", items_sent,
             checked_count);
    $display("over directed cases, a full board scan and four idle/stall phases.");
    if (fail_count == 0 && pending_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/zph_pkg.sv
hdl/zph_key_ram.sv
hdl/zph_keygen.sv
hdl/zobrist_position_hasher.sv
test/zph_checker.sv
test/tb_zobrist_position_hasher.sv
